### rtl/packet_reorder_jitter_buffer_assert.svh
// Assertion macros for the packet reorder jitter buffer.
`ifndef PACKET_REORDER_JITTER_BUFFER_ASSERT_SVH
`define PACKET_REORDER_JITTER_BUFFER_ASSERT_SVH
`ifndef SYNTHESIS
`define PRJB_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("jitter buffer check failed");
`define PRJB_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("jitter buffer check failed through reset");
`else
`define PRJB_ASSERT(name, prop)
`define PRJB_ASSERT_RST(name, prop)
`endif
`endif

### rtl/prjb_pkg.sv
// Types and constants shared by the jitter buffer controller.
`timescale 1ns / 1ps
package prjb_pkg;

  localparam int SEQ_W        = 16;
  localparam int SLOT_FIELD_W = 9;
  localparam int CNT_W        = 15;
  localparam int FILL_W       = 9;

  // Start level after reset.
  localparam logic [FILL_W-1:0] DEFAULT_FILL = 9'd282;

  // Last-chance resends at CHANCE_FIRST, then doubling, four in all.
  localparam int CHANCE_FIRST = 16;
  localparam int NUM_CHANCE   = 4;
  localparam int NUM_CAND     = NUM_CHANCE + 1;

  typedef enum logic [1:0] {
    CMD_PACKET = 2'd0,
    CMD_FETCH  = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    KIND_PLACED       = 4'd0,
    KIND_LATE_DROP    = 4'd1,
    KIND_RESEND       = 4'd2,
    KIND_PLAY         = 4'd3,
    KIND_PLAY_MISSING = 4'd4,
    KIND_WAITING      = 4'd5,
    KIND_UNDERRUN     = 4'd6,
    KIND_RESUMED      = 4'd7,
    KIND_FLUSHED      = 4'd8
  } kind_t;

  typedef struct packed {
    kind_t                   kind;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [SEQ_W-1:0]        first_seq;
    logic [CNT_W-1:0]        request_count;
    logic                    overrun;
  } result_t;

endpackage

### rtl/prjb_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module prjb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/packet_reorder_jitter_buffer.sv
// Jitter buffer controller: packet placement, playback fetch and resend requests.
//
// Each input word carries a command in s_tuser (packet arrived, fetch next frame, flush)
// and a 16-bit sequence number in s_tdata. The block keeps write and read pointers over
// SLOTS frame slots (SLOTS must be a power of two) and one ready bit per slot, and answers
// every word with one to five result words on the master side, the final one marked by
// m_tlast; the unused command code gives no result. A word is accepted in any cycle in
// which the block holds no unsent results beyond the one leaving that cycle, so a packet
// gives one to three results and a fetch up to five; the output register decouples
// the two sides so a new word can enter while a finished result still waits. A word
// with more than one result holds the input until its last result is sent, and a stall
// on the result side holds it longer. The slot
// ready bits live in five identical RAM copies so that a fetch can look up the slot to
// play and the four last-chance slots at once; their registered read data is used from the
// cycle after the fetch is accepted. After reset and after every flush a clearing pass
// writes all SLOTS ready bits to zero, one per cycle, so input is held off until the
// pass ends; configuration writes are taken at any time and should only be issued while
// the block is idle.
`timescale 1ns / 1ps
`include "packet_reorder_jitter_buffer_assert.svh"
module packet_reorder_jitter_buffer #(
  parameter int SLOTS = 512
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: start level, the frames buffered before playback starts.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,    // seq_num[15:0]
  input  logic [1:0]  s_tuser,    // cmd[1:0]
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,    // slot[8:0], first_seq[24:9], request_count[39:25],
                                  // overrun[40], zero[47:41]
  output logic [3:0]  m_tuser,    // kind[3:0]
  output logic        m_tlast
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int NCAND  = prjb_pkg::NUM_CAND;
  localparam int NCH    = prjb_pkg::NUM_CHANCE;
  localparam logic [15:0] SLOT_MASK = 16'(SLOTS - 1);

  // Slot number as reported in the result, limited to the result field width.
  function automatic logic [8:0] slot_field(input logic [15:0] s);
    slot_field = 9'(s & SLOT_MASK);
  endfunction

  // Controller state.
  logic [15:0] write_seq, write_seq_next;
  logic [15:0] read_seq, read_seq_next;
  logic        synced, synced_next;
  logic        buffering, buffering_next;
  logic        resume_pending, resume_pending_next;
  logic [8:0]  start_level;

  // Clearing pass over the ready bits.
  logic              clr_busy;
  logic [SLOT_W-1:0] clr_addr;

  // Pending results of the item in flight.
  prjb_pkg::result_t b_cand [NCAND];
  logic [NCAND-1:0]  b_en;
  logic [NCH-1:0]    b_chk;
  logic              b_play;

  // Output register.
  prjb_pkg::result_t out_res;

  // Input decode.
  prjb_pkg::cmd_t cmd;
  logic [15:0]    seq;
  logic           accept;

  // Packet path.
  logic [15:0] ws0, rs0, ws1, d_w, d_r, fill_pkt, rs_inc;
  logic        pkt_next, pkt_gap, pkt_late, pkt_placed, fill_ok, do_resume;

  // Fetch path.
  logic [15:0] fill_cur, play_seq, rs_play;
  logic        hold, ovr;
  logic [15:0] nx [NCH];

  // Next item's results and memory access.
  prjb_pkg::result_t cand [NCAND];
  logic [NCAND-1:0]  new_en;
  logic [NCH-1:0]    new_chk;
  logic              new_play;
  logic              item_we, item_wd, fetch_rd, start_clr;
  logic [SLOT_W-1:0] item_wa;

  // RAM ports.
  logic              ram_we, ram_wd;
  logic [SLOT_W-1:0] ram_wa;
  logic [SLOT_W-1:0] ram_ra [NCAND];
  logic [NCAND-1:0]  ram_rd;

  // Result selection.
  logic [NCAND-1:0]  eff_en, sel_mask;
  logic [2:0]        sel;
  logic              sel_last, emit;
  prjb_pkg::result_t sel_res;

  assign cmd    = prjb_pkg::cmd_t'(s_tuser);
  assign seq    = s_tdata;
  assign accept = s_tvalid && s_tready;

  assign cfg_ready = 1'b1;

  // A packet before sync defines both pointers.
  always_comb begin
    ws0        = synced ? write_seq : seq;
    rs0        = synced ? read_seq : 16'(seq - 16'd1);
    d_w        = 16'(seq - ws0);
    d_r        = 16'(seq - rs0);
    pkt_next   = (d_w == 16'd1);
    pkt_gap    = !pkt_next && (d_w != 16'd0) && !d_w[15];
    pkt_late   = !pkt_next && !pkt_gap && (d_r != 16'd0) && !d_r[15];
    pkt_placed = pkt_next || pkt_gap || pkt_late;
    ws1        = (pkt_next || pkt_gap) ? seq : ws0;
    fill_pkt   = 16'(ws1 - rs0);
    fill_ok    = !fill_pkt[15] && (fill_pkt[14:0] >= {6'd0, start_level});
    do_resume  = buffering && fill_ok && resume_pending;
    rs_inc     = 16'(rs0 + 16'd1);
  end

  // Fetch: hold, or play with an optional overrun repositioning.
  always_comb begin
    fill_cur = 16'(write_seq - read_seq);
    hold     = fill_cur[15] || (fill_cur == 16'd0) || !synced || buffering;
    ovr      = ({1'b0, fill_cur} >= 17'(SLOTS));
    play_seq = ovr ? 16'(write_seq - {7'd0, start_level}) : read_seq;
    rs_play  = 16'(play_seq + 16'd1);
    for (int i = 0; i < NCH; i++) begin
      nx[i] = 16'(rs_play + (16'(prjb_pkg::CHANCE_FIRST) << i));
    end
  end

  // Next state, candidate results and memory access for the offered item.
  always_comb begin
    write_seq_next      = write_seq;
    read_seq_next       = read_seq;
    synced_next         = synced;
    buffering_next      = buffering;
    resume_pending_next = resume_pending;
    new_en              = '0;
    new_chk             = '0;
    new_play            = 1'b0;
    item_we             = 1'b0;
    item_wd             = 1'b0;
    item_wa             = seq[SLOT_W-1:0];
    fetch_rd            = 1'b0;
    start_clr           = 1'b0;
    for (int i = 0; i < NCAND; i++) begin
      cand[i] = '{kind: prjb_pkg::KIND_PLACED, slot: '0, first_seq: '0,
                  request_count: '0, overrun: 1'b0};
    end
    unique case (cmd)
      prjb_pkg::CMD_PACKET: begin
        synced_next    = 1'b1;
        write_seq_next = ws1;
        buffering_next = buffering && !fill_ok;
        read_seq_next  = do_resume ? rs_inc : rs0;
        if (do_resume) begin
          resume_pending_next = 1'b0;
        end
        cand[0].kind          = prjb_pkg::KIND_RESEND;
        cand[0].first_seq     = 16'(ws0 + 16'd1);
        cand[0].request_count = 15'(d_w - 16'd1);
        cand[1].kind          = pkt_placed ? prjb_pkg::KIND_PLACED : prjb_pkg::KIND_LATE_DROP;
        cand[1].slot          = pkt_placed ? slot_field(seq) : 9'd0;
        cand[2].kind          = prjb_pkg::KIND_RESUMED;
        cand[2].slot          = slot_field(rs_inc);
        new_en                = {2'b00, do_resume, 1'b1, pkt_gap};
        item_we               = pkt_placed;
        item_wd               = 1'b1;
      end
      prjb_pkg::CMD_FETCH: begin
        if (hold) begin
          buffering_next      = 1'b1;
          resume_pending_next = 1'b1;
          cand[0].kind        = (synced && !buffering) ? prjb_pkg::KIND_UNDERRUN
                                                       : prjb_pkg::KIND_WAITING;
          new_en              = 5'b00001;
        end else begin
          read_seq_next = rs_play;
          for (int i = 0; i < NCH; i++) begin
            cand[i].kind          = prjb_pkg::KIND_RESEND;
            cand[i].first_seq     = nx[i];
            cand[i].request_count = 15'd1;
            cand[i].overrun       = ovr;
          end
          cand[NCAND-1].kind    = prjb_pkg::KIND_PLAY;
          cand[NCAND-1].slot    = slot_field(play_seq);
          cand[NCAND-1].overrun = ovr;
          new_en                = '1;
          new_chk               = '1;
          new_play              = 1'b1;
          fetch_rd              = 1'b1;
          item_we               = 1'b1;
          item_wd               = 1'b0;
          item_wa               = play_seq[SLOT_W-1:0];
        end
      end
      prjb_pkg::CMD_FLUSH: begin
        synced_next    = 1'b0;
        buffering_next = 1'b1;
        cand[0].kind   = prjb_pkg::KIND_FLUSHED;
        new_en         = 5'b00001;
        start_clr      = 1'b1;
      end
      default: begin
        // The unused command code changes nothing and gives no result.
      end
    endcase
  end

  // Ready bit storage: one RAM copy per lookup address, all written alike.
  assign ram_we = clr_busy || (accept && item_we);
  assign ram_wa = clr_busy ? clr_addr : item_wa;
  assign ram_wd = !clr_busy && item_wd;

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      ram_ra[i] = nx[i][SLOT_W-1:0];
    end
    ram_ra[NCAND-1] = play_seq[SLOT_W-1:0];
  end

  for (genvar g = 0; g < NCAND; g++) begin : g_ready_ram
    prjb_ram #(
      .WIDTH (1),
      .DEPTH (SLOTS)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (ram_wa),
      .wdata (ram_wd),
      .re    (accept && fetch_rd),
      .raddr (ram_ra[g]),
      .rdata (ram_rd[g])
    );
  end

  // A last-chance resend is only sent when its slot is not yet ready.
  always_comb begin
    eff_en = b_en & ~{1'b0, b_chk & ram_rd[NCH-1:0]};
    sel_mask = eff_en & ~NCAND'(eff_en - NCAND'(1));
    sel_last = ((eff_en & ~sel_mask) == '0);
    sel = '0;
    for (int i = NCAND - 1; i >= 0; i--) begin
      if (eff_en[i]) begin
        sel = 3'(i);
      end
    end
    sel_res = b_cand[sel];
    if (b_play && (sel == 3'(NCAND - 1)) && !ram_rd[NCAND-1]) begin
      sel_res.kind = prjb_pkg::KIND_PLAY_MISSING;
    end
  end

  assign emit     = (eff_en != '0) && (!m_tvalid || m_tready);
  assign s_tready = !clr_busy && ((eff_en == '0) || (emit && sel_last));

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_seq      <= '0;
      read_seq       <= '0;
      synced         <= 1'b0;
      buffering      <= 1'b1;
      resume_pending <= 1'b0;
      start_level    <= prjb_pkg::DEFAULT_FILL;
      clr_busy       <= 1'b1;
      clr_addr       <= '0;
      b_en           <= '0;
      b_chk          <= '0;
      b_play         <= 1'b0;
      m_tvalid       <= 1'b0;
      m_tlast        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        start_level <= cfg_data;
      end
      if (accept && start_clr) begin
        clr_busy <= 1'b1;
        clr_addr <= '0;
      end else if (clr_busy) begin
        clr_addr <= SLOT_W'(clr_addr + 1'b1);
        if (clr_addr == SLOT_W'(SLOTS - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      if (emit) begin
        m_tvalid <= 1'b1;
        m_tlast  <= sel_last;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // The next item's results replace the last one leaving in the same cycle.
      if (accept) begin
        write_seq      <= write_seq_next;
        read_seq       <= read_seq_next;
        synced         <= synced_next;
        buffering      <= buffering_next;
        resume_pending <= resume_pending_next;
        b_en           <= new_en;
        b_chk          <= new_chk;
        b_play         <= new_play;
      end else if (emit) begin
        b_en <= b_en & ~sel_mask;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      b_cand <= cand;
    end
    if (emit) begin
      out_res <= sel_res;
    end
  end

  assign m_tdata = {7'd0, out_res.overrun, out_res.request_count, out_res.first_seq,
                    out_res.slot};
  assign m_tuser = out_res.kind;

  // Playback can only be running once a stream has been synced.
  `PRJB_ASSERT_RST(a_run_needs_sync, !rst && !buffering |-> synced)
  // A pending resume only exists while playback is held.
  `PRJB_ASSERT_RST(a_resume_while_held, !rst && resume_pending |-> buffering)
  // A flush drops sync and starts a clearing pass.
  `PRJB_ASSERT(a_flush_clears, accept && cmd == prjb_pkg::CMD_FLUSH |=> !synced && clr_busy)
  // No item enters while results of the previous one are still queued behind this word.
  `PRJB_ASSERT(a_no_overlap, accept && !sel_last |-> eff_en == '0)

endmodule
